// ===== sv/yrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to RGB brightness package
// Shared widths, register codes, reset values, conversion coefficients and
// payload types of the YUYV to adjusted RGB888 converter.
// ----------------------------------------------------------------------------
package yrb_pkg;

  // Field and register widths.
  localparam int unsigned PixW     = 8;
  localparam int unsigned GainW    = 10;
  localparam int unsigned OffsetW  = 8;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW  = 1;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgGain   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOffset = 1'b1;

  // Register values after reset: gain 1.25 in Q2.8, offset 25.
  localparam logic [GainW-1:0]   GainReset   = 10'd320;
  localparam logic [OffsetW-1:0] OffsetReset = 8'd25;

  // Default depth of the result buffer; it must cover the pipeline plus two.
  localparam int unsigned FifoDepthDefault = 8;

  // Width of the signed conversion sums (largest magnitude is below 2^18).
  localparam int unsigned SumW = 20;

  // Integer BT.601 coefficients and rounding constant.
  localparam logic signed [SumW-1:0] CoefY  = 20'sd298;
  localparam logic signed [SumW-1:0] CoefRV = 20'sd409;
  localparam logic signed [SumW-1:0] CoefGU = 20'sd100;
  localparam logic signed [SumW-1:0] CoefGV = 20'sd208;
  localparam logic signed [SumW-1:0] CoefBU = 20'sd516;
  localparam logic signed [SumW-1:0] Round  = 20'sd128;

  // Chroma contributions shared by both lanes.
  typedef struct packed {
    logic signed [SumW-1:0] r;
    logic signed [SumW-1:0] g;
    logic signed [SumW-1:0] b;
  } chroma_terms_t;

  // One adjusted RGB pixel.
  typedef struct packed {
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
  } rgb_t;

  // One result item: two pixels and the end-of-frame marker.
  typedef struct packed {
    rgb_t first;
    rgb_t second;
    logic frame_end;
  } pair_t;

endpackage

// ===== sv/yrb_pix_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV macropixel stream interface
// Valid/ready channel that carries one YUYV macropixel per transfer.
// ----------------------------------------------------------------------------
interface yrb_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;
  logic       frame_end_in;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
    input  ready
  );

  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
    output ready
  );
endinterface

// ===== sv/yrb_pix_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB pixel pair stream interface
// Valid/ready channel that carries two adjusted RGB888 pixels per transfer.
// ----------------------------------------------------------------------------
interface yrb_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;
  logic       frame_end_out;

  modport source (
    output valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    input  ready
  );

  modport sink (
    input  valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    output ready
  );
endinterface

// ===== sv/yrb_chroma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared chroma terms
// Removes the chroma bias and forms the registered U and V contributions to
// red, green and blue that both pixel lanes add to their luma term.
// ----------------------------------------------------------------------------
module yrb_chroma
  import yrb_pkg::*;
(
  input  logic                clk_i,
  input  logic [PixW-1:0]     chroma_blue_i,
  input  logic [PixW-1:0]     chroma_red_i,
  output chroma_terms_t       terms_o
);

  logic signed [PixW-1:0] d;
  logic signed [PixW-1:0] e;
  chroma_terms_t          terms_d;
  chroma_terms_t          terms_q;

  // Subtracting 128 from an 8-bit sample is an inversion of its top bit.
  assign d = $signed({~chroma_blue_i[PixW-1], chroma_blue_i[PixW-2:0]});
  assign e = $signed({~chroma_red_i[PixW-1], chroma_red_i[PixW-2:0]});

  // Constant multiplications; green carries both chroma terms with a minus sign.
  always_comb begin
    terms_d.r = SumW'(e) * CoefRV;
    terms_d.g = -((SumW'(d) * CoefGU) + (SumW'(e) * CoefGV));
    terms_d.b = SumW'(d) * CoefBU;
  end

  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
  end

  assign terms_o = terms_q;

endmodule

// ===== sv/yrb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel conversion lane
// Converts one luma sample plus the shared chroma terms into an RGB pixel,
// clamps each channel and applies the contrast gain and brightness offset.
// ----------------------------------------------------------------------------
module yrb_lane
  import yrb_pkg::*;
(
  input  logic                clk_i,
  input  logic [PixW-1:0]     luma_i,
  input  chroma_terms_t       terms_i,
  input  logic [GainW-1:0]    gain_i,
  input  logic [OffsetW-1:0]  offset_i,
  output rgb_t                rgb_o
);

  localparam int unsigned ProdW = PixW + GainW;
  localparam int unsigned AdjW  = ProdW - 8 + 1;

  // Floor shift by eight of a signed sum, clamped to 0..255.
  function automatic logic [PixW-1:0] clamp_shift(logic signed [SumW-1:0] s);
    logic [PixW-1:0] v;
    if (s[SumW-1]) begin
      v = '0;
    end else if (|s[SumW-2:PixW+8]) begin
      v = '1;
    end else begin
      v = s[PixW+7:8];
    end
    return v;
  endfunction

  // Drops the gain fraction, adds the offset and saturates at 255.
  function automatic logic [PixW-1:0] adjust(logic [ProdW-1:0] p,
                                             logic [OffsetW-1:0] off);
    logic [AdjW-1:0] v;
    v = AdjW'(p[ProdW-1:8]) + AdjW'(off);
    return (|v[AdjW-1:PixW]) ? '1 : v[PixW-1:0];
  endfunction

  logic signed [PixW:0]    c;
  logic signed [SumW-1:0]  y_term_q;
  logic signed [SumW-1:0]  base;
  rgb_t                    ch_q;
  logic [ProdW-1:0]        prod_r_q;
  logic [ProdW-1:0]        prod_g_q;
  logic [ProdW-1:0]        prod_b_q;

  // Luma term, aligned with the registered chroma terms.
  assign c = $signed({1'b0, luma_i}) - 9'sd16;

  always_ff @(posedge clk_i) begin
    y_term_q <= SumW'(c) * CoefY;
  end

  // Channel sums with rounding, then clamping.
  assign base = y_term_q + Round;

  always_ff @(posedge clk_i) begin
    ch_q.r <= clamp_shift(base + terms_i.r);
    ch_q.g <= clamp_shift(base + terms_i.g);
    ch_q.b <= clamp_shift(base + terms_i.b);
  end

  // Contrast gain products.
  always_ff @(posedge clk_i) begin
    prod_r_q <= ProdW'(ch_q.r) * ProdW'(gain_i);
    prod_g_q <= ProdW'(ch_q.g) * ProdW'(gain_i);
    prod_b_q <= ProdW'(ch_q.b) * ProdW'(gain_i);
  end

  // Brightness offset and saturation.
  always_comb begin
    rgb_o.r = adjust(prod_r_q, offset_i);
    rgb_o.g = adjust(prod_g_q, offset_i);
    rgb_o.b = adjust(prod_b_q, offset_i);
  end

endmodule

// ===== sv/yrb_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result merge and output buffer
// Joins the two lane pixels and the end-of-frame marker into one result,
// buffers results and grants input credits so the pipeline never stalls.
// ----------------------------------------------------------------------------
module yrb_out_stage
  import yrb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  output logic                 in_ready_o,
  input  logic                 wr_valid_i,
  input  rgb_t                 first_i,
  input  rgb_t                 second_i,
  input  logic                 frame_end_i,
  yrb_pix_out_if.source        pix_out
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(FIFO_DEPTH);

  pair_t           mem_q [FIFO_DEPTH];
  pair_t           wr_data;
  pair_t           rd_data;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_xfer;

  // Merge of the lane results into one item.
  always_comb begin
    wr_data.first     = first_i;
    wr_data.second    = second_i;
    wr_data.frame_end = frame_end_i;
  end

  assign out_xfer = pix_out.valid && pix_out.ready;

  // Input credit: items accepted but not yet transferred out never exceed
  // the buffer depth, so a result always finds a free entry.
  assign in_ready_o = (cnt_q < Depth);

  always_comb begin
    cnt_d = cnt_q;
    case ({in_accept_i, out_xfer})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Buffer pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (wr_valid_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (out_xfer) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_valid_i, out_xfer})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
    end
  end

  // Buffer storage.
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data;
    end
  end

  // Output channel driven from the head entry.
  assign rd_data = mem_q[rd_ptr_q];

  always_comb begin
    pix_out.valid         = (fill_q != '0);
    pix_out.red_first     = rd_data.first.r;
    pix_out.green_first   = rd_data.first.g;
    pix_out.blue_first    = rd_data.first.b;
    pix_out.red_second    = rd_data.second.r;
    pix_out.green_second  = rd_data.second.g;
    pix_out.blue_second   = rd_data.second.b;
    pix_out.frame_end_out = rd_data.frame_end;
  end

  // Buffered results are always a subset of the items holding credit.
  a_fill_le_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cnt_q)
    else $error("buffer holds more results than items in flight");

  // A result from the pipeline must always find a free entry.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> (fill_q < Depth))
    else $error("result written into a full buffer");

  // Credits never exceed the buffer depth.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("input credit count above buffer depth");

  // Every accepted item reaches the buffer at the end of the pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i |-> ##4 wr_valid_i)
    else $error("accepted item did not reach the buffer in time");

endmodule

// ===== sv/yuyv_to_rgb_brightness.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to RGB888 converter with brightness and contrast
// Converts one YUYV macropixel per transfer into two adjusted RGB pixels.
// ----------------------------------------------------------------------------
// The block takes one macropixel per clock and gives one pixel pair per
// clock: two conversion lanes share one chroma unit, and every stage works
// on a new item each cycle. A result passes the input, term, clamp and gain
// product registers and then the output buffer. The pipeline never
// stalls; input ready drops only when FIFO_DEPTH items are accepted but not
// yet transferred out, so with an output that keeps up the sustained rate is
// one item per cycle. The user must write contrast gain and brightness offset
// through the configuration port while no item is in flight; it is not enforced.
module yuyv_to_rgb_brightness
  import yrb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  yrb_pix_in_if.sink           pix_in,
  yrb_pix_out_if.source        pix_out
);

  logic               in_accept;
  logic               in_ready;
  logic [GainW-1:0]   gain_q, gain_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [PixW-1:0]    luma0_q, luma1_q, cb_q, cr_q;
  logic [3:0]         vld_q;
  logic [3:0]         fe_q;
  chroma_terms_t      terms;
  rgb_t               rgb_first;
  rgb_t               rgb_second;

  assign pix_in.ready = in_ready;
  assign in_accept    = pix_in.valid && in_ready;

  // Configuration register decode.
  always_comb begin
    gain_d   = gain_q;
    offset_d = offset_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgGain:   gain_d   = cfg_data_i[GainW-1:0];
        CfgOffset: offset_d = cfg_data_i[OffsetW-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GainReset;
      offset_q <= OffsetReset;
    end else begin
      gain_q   <= gain_d;
      offset_q <= offset_d;
    end
  end

  // Input register stage; the payload loads every cycle.
  always_ff @(posedge clk_i) begin
    luma0_q <= pix_in.luma_first;
    luma1_q <= pix_in.luma_second;
    cb_q    <= pix_in.chroma_blue;
    cr_q    <= pix_in.chroma_red;
    fe_q    <= {fe_q[2:0], pix_in.frame_end_in};
  end

  // Valid bits that follow each item through the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_accept};
    end
  end

  // Shared chroma unit.
  yrb_chroma u_chroma (
    .clk_i         (clk_i),
    .chroma_blue_i (cb_q),
    .chroma_red_i  (cr_q),
    .terms_o       (terms)
  );

  // One lane for each pixel of the pair.
  yrb_lane u_lane_first (
    .clk_i    (clk_i),
    .luma_i   (luma0_q),
    .terms_i  (terms),
    .gain_i   (gain_q),
    .offset_i (offset_q),
    .rgb_o    (rgb_first)
  );

  yrb_lane u_lane_second (
    .clk_i    (clk_i),
    .luma_i   (luma1_q),
    .terms_i  (terms),
    .gain_i   (gain_q),
    .offset_i (offset_q),
    .rgb_o    (rgb_second)
  );

  // Merge of the lane results and output buffering.
  yrb_out_stage #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_ready_o  (in_ready),
    .wr_valid_i  (vld_q[3]),
    .first_i     (rgb_first),
    .second_i    (rgb_second),
    .frame_end_i (fe_q[3]),
    .pix_out     (pix_out)
  );

endmodule
